>>> hdl/kat_pkg.sv
// kat_pkg: shared types and constants for the keyed accumulate table
// holds operation and status codes, sequencer states, the write-port struct and the result struct
// no dependencies
package kat_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 48;
	localparam int OP_W  = 2;
	localparam int ST_W  = 3;

	typedef enum logic [OP_W-1:0] {
		OP_ADD     = 2'd0,
		OP_SUB     = 2'd1,
		OP_READOUT = 2'd2
	} kat_op_t;

	typedef enum logic [ST_W-1:0] {
		STAT_MERGED   = 3'd0,
		STAT_APPENDED = 3'd1,
		STAT_DROPPED  = 3'd2,
		STAT_ENTRY    = 3'd3,
		STAT_EMPTY    = 3'd4
	} kat_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_OUT,
		ST_DUMP_RD,
		ST_DUMP_OUT
	} kat_state_t;

	// table write port
	typedef struct packed {
		logic                    we;
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] value;
	} kat_wr_t;

	// one result item
	typedef struct packed {
		kat_status_t             status;
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} kat_result_t;

endpackage

>>> hdl/kat_if.sv
// kat_req_if and kat_rsp_if: valid/ready channels for tuples and results
// depends on kat_pkg for field widths
interface kat_req_if;
	logic                             valid;
	logic                             ready;
	logic [kat_pkg::OP_W-1:0]         operation;
	logic [kat_pkg::KEY_W-1:0]        tuple_key;
	logic signed [kat_pkg::VAL_W-1:0] tuple_value;

	modport source (output valid, operation, tuple_key, tuple_value, input ready);
	modport sink (input valid, operation, tuple_key, tuple_value, output ready);
endinterface

interface kat_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [kat_pkg::ST_W-1:0]         status;
	logic [kat_pkg::KEY_W-1:0]        out_key;
	logic signed [kat_pkg::VAL_W-1:0] out_value;
	logic                             last;

	modport source (output valid, status, out_key, out_value, last, input ready);
	modport sink (input valid, status, out_key, out_value, last, output ready);
endinterface

>>> hdl/kat_table_mem.sv
// kat_table_mem: key and value storage, one write and one registered read port
// depends on kat_pkg
module kat_table_mem #(
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  kat_pkg::kat_wr_t                 wr,
	input  logic [$clog2(DEPTH)-1:0]         wr_addr,
	input  logic                             rd_en,
	input  logic [$clog2(DEPTH)-1:0]         rd_addr,
	output logic [kat_pkg::KEY_W-1:0]        rd_key,
	output logic signed [kat_pkg::VAL_W-1:0] rd_value
);
	import kat_pkg::*;

	logic [KEY_W-1:0]        keys_q   [DEPTH];
	logic signed [VAL_W-1:0] values_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr.we) begin
			keys_q[wr_addr]   <= wr.key;
			values_q[wr_addr] <= wr.value;
		end
	end

	// registered read, holds while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key   <= keys_q[rd_addr];
			rd_value <= values_q[rd_addr];
		end
	end

endmodule

>>> hdl/kat_sat_alu.sv
// kat_sat_alu: shared saturating add/subtract on Q32.16 values
// depends on kat_pkg
module kat_sat_alu (
	input  logic signed [kat_pkg::VAL_W-1:0] a,
	input  logic signed [kat_pkg::VAL_W-1:0] b,
	input  logic                             sub,
	output logic signed [kat_pkg::VAL_W-1:0] res
);
	import kat_pkg::*;

	localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

	logic [VAL_W:0] sum;

	// one extra bit catches overflow
	always_comb begin
		if (sub)
			sum = {a[VAL_W-1], a} - {b[VAL_W-1], b};
		else
			sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (sum[VAL_W] != sum[VAL_W-1])
			res = sum[VAL_W] ? VMIN : VMAX;
		else
			res = sum[VAL_W-1:0];
	end

endmodule

>>> hdl/kat_seq.sv
// kat_seq: sequencer for key search, append, merge, drop and readout
// depends on kat_pkg, kat_if; drives kat_table_mem and kat_sat_alu
module kat_seq #(
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	kat_req_if.sink                          req,
	kat_rsp_if.source                        rsp,
	output kat_pkg::kat_wr_t                 wr,
	output logic [$clog2(DEPTH)-1:0]         wr_addr,
	output logic                             rd_en,
	output logic [$clog2(DEPTH)-1:0]         rd_addr,
	input  logic [kat_pkg::KEY_W-1:0]        rd_key,
	input  logic signed [kat_pkg::VAL_W-1:0] rd_value,
	output logic signed [kat_pkg::VAL_W-1:0] alu_a,
	output logic signed [kat_pkg::VAL_W-1:0] alu_b,
	output logic                             alu_sub,
	input  logic signed [kat_pkg::VAL_W-1:0] alu_res
);
	import kat_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	kat_state_t              state_q, state_d;
	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic [CNT_W-1:0]        iss_q, iss_d;
	logic                    pend_s1, pend_d;
	logic [IDX_W-1:0]        pend_idx_s1;
	logic                    sub_q;
	logic [KEY_W-1:0]        key_q;
	logic signed [VAL_W-1:0] val_q;
	logic                    ld_tup;
	kat_result_t             res_q, res_d;
	logic                    hit;
	logic                    dump_last;

	// compare the entry read in the previous cycle
	assign hit       = pend_s1 && (rd_key == key_q);
	assign dump_last = (iss_q == cnt_q - CNT_W'(1));

	// shared unit: stored value or zero, combined with the tuple value
	assign alu_a   = hit ? rd_value : '0;
	assign alu_b   = val_q;
	assign alu_sub = sub_q;

	// next state and outputs
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		iss_d   = iss_q;
		pend_d  = 1'b0;
		ld_tup  = 1'b0;
		res_d   = res_q;
		rd_en   = 1'b0;
		rd_addr = iss_q[IDX_W-1:0];
		wr      = '0;
		wr_addr = cnt_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					iss_d = '0;
					unique case (req.operation)
						OP_ADD, OP_SUB: begin
							ld_tup  = 1'b1;
							state_d = ST_SCAN;
						end
						OP_READOUT: begin
							if (cnt_q == '0) begin
								res_d.status = STAT_EMPTY;
								res_d.key    = '0;
								res_d.value  = '0;
								res_d.last   = 1'b1;
								state_d      = ST_OUT;
							end else begin
								state_d = ST_DUMP_RD;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				res_d.key  = key_q;
				res_d.last = 1'b1;
				priority if (hit) begin
					wr.we        = 1'b1;
					wr.key       = key_q;
					wr.value     = alu_res;
					wr_addr      = pend_idx_s1;
					res_d.status = STAT_MERGED;
					res_d.value  = alu_res;
					state_d      = ST_OUT;
				end else if (iss_q != cnt_q) begin
					rd_en  = 1'b1;
					pend_d = 1'b1;
					iss_d  = iss_q + CNT_W'(1);
				end else if (cnt_q == FULL) begin
					res_d.status = STAT_DROPPED;
					res_d.value  = '0;
					state_d      = ST_OUT;
				end else begin
					wr.we        = 1'b1;
					wr.key       = key_q;
					wr.value     = alu_res;
					cnt_d        = cnt_q + CNT_W'(1);
					res_d.status = STAT_APPENDED;
					res_d.value  = alu_res;
					state_d      = ST_OUT;
				end
			end
			ST_OUT: begin
				if (rsp.ready)
					state_d = ST_IDLE;
			end
			ST_DUMP_RD: begin
				rd_en   = 1'b1;
				state_d = ST_DUMP_OUT;
			end
			ST_DUMP_OUT: begin
				if (rsp.ready) begin
					if (dump_last) begin
						cnt_d   = '0;
						state_d = ST_IDLE;
					end else begin
						iss_d   = iss_q + CNT_W'(1);
						state_d = ST_DUMP_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			iss_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			iss_q   <= iss_d;
			pend_s1 <= pend_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		res_q       <= res_d;
		pend_idx_s1 <= iss_q[IDX_W-1:0];
		if (ld_tup) begin
			sub_q <= (req.operation == OP_SUB);
			key_q <= req.tuple_key;
			val_q <= req.tuple_value;
		end
	end

	// handshake and result mux
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = (state_q == ST_OUT) || (state_q == ST_DUMP_OUT);
	always_comb begin
		if (state_q == ST_DUMP_OUT) begin
			rsp.status    = STAT_ENTRY;
			rsp.out_key   = rd_key;
			rsp.out_value = rd_value;
			rsp.last      = dump_last;
		end else begin
			rsp.status    = res_q.status;
			rsp.out_key   = res_q.key;
			rsp.out_value = res_q.value;
			rsp.last      = res_q.last;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL)
		else $error("entry count beyond table depth");
	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("tuple taken while a result is pending");
	a_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> (state_q == ST_SCAN))
		else $error("table written outside the search");
	a_dump_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP_OUT && rsp.ready && dump_last) |=> (cnt_q == '0))
		else $error("table not empty after readout");
	a_pend_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == ST_SCAN))
		else $error("compare pending outside the search");
`endif

endmodule

>>> hdl/keyed_accumulate_table_unit.sv
// keyed_accumulate_table_unit: bounded sparse vector, one comparator scans a key per cycle
// add/subtract: scans the stored entries, one read per cycle, until a key matches, then merges, appends or drops
// readout: each entry is read, then held as a result until taken; an empty table gives a single empty result
// one item in work at a time; the next item can be taken in the cycle after its last result is accepted
// reset clears entry count and sequencer; table contents stay undefined, no clearing pass
module keyed_accumulate_table_unit #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	kat_req_if.sink   req,
	kat_rsp_if.source rsp
);
	import kat_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	kat_wr_t                 wr;
	logic [IDX_W-1:0]        wr_addr;
	logic                    rd_en;
	logic [IDX_W-1:0]        rd_addr;
	logic [KEY_W-1:0]        rd_key;
	logic signed [VAL_W-1:0] rd_value;
	logic signed [VAL_W-1:0] alu_a;
	logic signed [VAL_W-1:0] alu_b;
	logic                    alu_sub;
	logic signed [VAL_W-1:0] alu_res;

	// sequencer
	kat_seq #(.DEPTH(TABLE_DEPTH)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.wr       (wr),
		.wr_addr  (wr_addr),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_key   (rd_key),
		.rd_value (rd_value),
		.alu_a    (alu_a),
		.alu_b    (alu_b),
		.alu_sub  (alu_sub),
		.alu_res  (alu_res)
	);

	// entry storage
	kat_table_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
		.clk      (clk),
		.wr       (wr),
		.wr_addr  (wr_addr),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_key   (rd_key),
		.rd_value (rd_value)
	);

	// shared saturating adder
	kat_sat_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.res (alu_res)
	);

endmodule
